[rtl/core/lcrg_pkg.sv]
// look-at camera ray generator: shared types and register codes
// payload structs for the uv and ray channels, config port sizing, basis sequencer states
`timescale 1ns / 1ps

package lcrg_pkg;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CAM_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM     = 3'd6;

	typedef struct packed {
		logic signed [15:0] uv_x;
		logic signed [15:0] uv_y;
	} uv_t;

	typedef struct packed {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic               degenerate;
	} ray_t;

	typedef enum logic [7:0] {
		B_IDLE = 8'b0000_0001,
		B_DIFF = 8'b0000_0010,
		B_MAX  = 8'b0000_0100,
		B_NORM = 8'b0000_1000,
		B_SQ   = 8'b0001_0000,
		B_SQRT = 8'b0010_0000,
		B_DIV  = 8'b0100_0000,
		B_MUL  = 8'b1000_0000
	} basis_state_t;

endpackage

[rtl/core/look_at_camera_ray_gen.sv]
// look-at camera ray generator top level: camera basis sequencer and per-ray pipeline
// depends on lcrg_pkg for payload structs, register codes and sequencer states
`timescale 1ns / 1ps

//  channel | signals                       | beat moves when
//  --------+-------------------------------+----------------------------
//  uv      | uv_valid, uv_stall, uv_data   | uv_valid && !uv_stall
//  ray     | ray_valid, ray_stall, ray_data| ray_valid && !ray_stall
//  cfg     | cfg_we, cfg_index, cfg_data   | cfg_we
//
// one ray per cycle while neither ray_stall nor the basis sequencer holds the flow
// pipeline: 8 front stages, 32 square-root stages, 16 divider stages, output register
// after reset or any config write the basis sequencer runs an iterative normalize,
// a 32-step square root, a 31-step divide and 7 products (skipped when degenerate);
// uv_stall stays high until it is back in idle
// a stall on ray while ray_valid is high freezes the whole pipeline in place, nothing is dropped or repeated

module look_at_camera_ray_gen (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 uv_valid,
	output logic                                 uv_stall,
	input  lcrg_pkg::uv_t                        uv_data,
	output logic                                 ray_valid,
	input  logic                                 ray_stall,
	output lcrg_pkg::ray_t                       ray_data,
	input  logic                                 cfg_we,
	input  logic [lcrg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lcrg_pkg::CFG_W-1:0]           cfg_data
);
	import lcrg_pkg::*;

	function automatic logic signed [32:0] rnd30(input logic signed [63:0] v);
		logic [63:0] m;
		logic [63:0] q;
		m = v[63] ? 64'(-v) : 64'(v);
		q = (m + (64'd1 << 29)) >> 30;
		rnd30 = v[63] ? -$signed(33'(q)) : $signed(33'(q));
	endfunction

	// ---------------- configuration registers ----------------
	logic signed [31:0] cam_q [3];
	logic signed [31:0] tgt_q [3];
	logic [30:0]        zoom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			tgt_q[0] <= '0;
			tgt_q[1] <= '0;
			tgt_q[2] <= 32'sd65536;
			zoom_q   <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAM_X:    cam_q[0] <= cfg_data;
				REG_CAM_Y:    cam_q[1] <= cfg_data;
				REG_CAM_Z:    cam_q[2] <= cfg_data;
				REG_TARGET_X: tgt_q[0] <= cfg_data;
				REG_TARGET_Y: tgt_q[1] <= cfg_data;
				REG_TARGET_Z: tgt_q[2] <= cfg_data;
				REG_ZOOM:     zoom_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// ---------------- basis sequencer ----------------
	basis_state_t       st_q;
	logic [4:0]         cnt_q;
	logic               bdeg_q;
	logic [32:0]        bm_q [3];
	logic               bsg_q [3];
	logic [32:0]        mx_q;
	logic [63:0]        acc_q;
	logic [63:0]        rres_q;
	logic [61:0]        dvr_q [3];
	logic [61:0]        dvd_q;
	logic [30:0]        fq_q [3];
	logic signed [32:0] f_q [3];
	logic signed [32:0] r_q [3];
	logic signed [32:0] u_q [3];
	logic signed [63:0] fz_q [3];
	logic signed [63:0] prod_q;

	logic signed [32:0] d_w [3];
	logic [32:0]        dmag_w [3];
	logic               dzero_w;
	logic [32:0]        mx_w;
	logic [63:0]        bit_w;
	logic [63:0]        t_w;
	logic               sge_w;
	logic [63:0]        rres_nx;
	logic [63:0]        x_nx;
	logic               dge_w [3];
	logic [30:0]        fq_nx [3];
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [63:0] prod_w;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d_w[c]    = 33'(tgt_q[c]) - 33'(cam_q[c]);
			dmag_w[c] = d_w[c][32] ? 33'(-d_w[c]) : 33'(d_w[c]);
		end
		dzero_w = (d_w[0] == '0) && (d_w[2] == '0);
		mx_w = bm_q[0];
		if (bm_q[1] > mx_w) mx_w = bm_q[1];
		if (bm_q[2] > mx_w) mx_w = bm_q[2];
	end

	// one digit of the square root per cycle
	assign bit_w   = 64'd1 << (6'd62 - 6'({cnt_q, 1'b0}));
	assign t_w     = rres_q + bit_w;
	assign sge_w   = acc_q >= t_w;
	assign rres_nx = sge_w ? (rres_q >> 1) + bit_w : rres_q >> 1;
	assign x_nx    = sge_w ? acc_q - t_w : acc_q;

	// one quotient bit per cycle for all three components
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dge_w[c] = dvr_q[c] >= dvd_q;
			fq_nx[c] = {fq_q[c][29:0], dge_w[c]};
		end
	end

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (st_q == B_SQ && cnt_q < 5'd3) begin
			mul_a = $signed(bm_q[cnt_q[1:0]]);
			mul_b = $signed(bm_q[cnt_q[1:0]]);
		end else if (st_q == B_MUL) begin
			unique case (cnt_q[2:0])
				3'd0: begin mul_a = f_q[0]; mul_b = f_q[1]; end
				3'd1: begin mul_a = f_q[0]; mul_b = f_q[0]; end
				3'd2: begin mul_a = f_q[2]; mul_b = f_q[2]; end
				3'd3: begin mul_a = f_q[1]; mul_b = f_q[2]; end
				3'd4: begin mul_a = f_q[0]; mul_b = $signed({2'b00, zoom_q}); end
				3'd5: begin mul_a = f_q[1]; mul_b = $signed({2'b00, zoom_q}); end
				3'd6: begin mul_a = f_q[2]; mul_b = $signed({2'b00, zoom_q}); end
				default: ;
			endcase
		end
	end

	assign prod_w = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= B_DIFF;
			cnt_q  <= '0;
			bdeg_q <= 1'b1;
		end else if (cfg_we) begin
			st_q  <= B_DIFF;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				B_IDLE: ;
				B_DIFF: begin
					bdeg_q <= dzero_w;
					st_q   <= dzero_w ? B_IDLE : B_MAX;
				end
				B_MAX: st_q <= B_NORM;
				B_NORM: begin
					if (mx_q < (33'd1 << 30) && mx_q >= (33'd1 << 29)) begin
						st_q  <= B_SQ;
						cnt_q <= '0;
					end
				end
				B_SQ: begin
					if (cnt_q == 5'd3) begin
						st_q  <= B_SQRT;
						cnt_q <= '0;
					end else cnt_q <= cnt_q + 5'd1;
				end
				B_SQRT: begin
					if (cnt_q == 5'd31) begin
						st_q  <= B_DIV;
						cnt_q <= '0;
					end else cnt_q <= cnt_q + 5'd1;
				end
				B_DIV: begin
					if (cnt_q == 5'd30) begin
						st_q  <= B_MUL;
						cnt_q <= '0;
					end else cnt_q <= cnt_q + 5'd1;
				end
				B_MUL: begin
					if (cnt_q == 5'd7) begin
						st_q  <= B_IDLE;
						cnt_q <= '0;
					end else cnt_q <= cnt_q + 5'd1;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_w;
		unique case (st_q)
			B_DIFF: begin
				for (int c = 0; c < 3; c++) begin
					bm_q[c]  <= dmag_w[c];
					bsg_q[c] <= d_w[c][32];
				end
			end
			B_MAX: mx_q <= mx_w;
			B_NORM: begin
				if (mx_q >= (33'd1 << 30)) begin
					for (int c = 0; c < 3; c++) bm_q[c] <= bm_q[c] >> 1;
					mx_q <= mx_q >> 1;
				end else if (mx_q < (33'd1 << 29)) begin
					for (int c = 0; c < 3; c++) bm_q[c] <= bm_q[c] << 1;
					mx_q <= mx_q << 1;
				end else begin
					acc_q <= '0;
				end
			end
			B_SQ: begin
				// product of the previous cycle lands here
				if (cnt_q != 5'd0) acc_q <= acc_q + 64'(prod_q);
				if (cnt_q == 5'd3) rres_q <= '0;
			end
			B_SQRT: begin
				acc_q  <= x_nx;
				rres_q <= rres_nx;
				if (cnt_q == 5'd31) begin
					dvd_q <= 62'(rres_nx) << 30;
					for (int c = 0; c < 3; c++)
						dvr_q[c] <= (62'(bm_q[c]) << 30) + 62'(rres_nx >> 1);
				end
			end
			B_DIV: begin
				for (int c = 0; c < 3; c++) begin
					if (dge_w[c]) dvr_q[c] <= dvr_q[c] - dvd_q;
					fq_q[c] <= fq_nx[c];
					if (cnt_q == 5'd30)
						f_q[c] <= bsg_q[c] ? -$signed({2'b00, fq_nx[c]})
						                   : $signed({2'b00, fq_nx[c]});
				end
				dvd_q <= dvd_q >> 1;
			end
			B_MUL: begin
				unique case (cnt_q[2:0])
					3'd0: begin
						r_q[0] <= f_q[2];
						r_q[1] <= '0;
						r_q[2] <= -f_q[0];
					end
					3'd1: u_q[0] <= rnd30(-prod_q);
					3'd2: acc_q <= 64'(prod_q);
					3'd3: u_q[1] <= rnd30($signed(acc_q) + prod_q);
					3'd4: u_q[2] <= rnd30(-prod_q);
					3'd5: fz_q[0] <= prod_q;
					3'd6: fz_q[1] <= prod_q;
					3'd7: fz_q[2] <= prod_q;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// ---------------- per-ray pipeline ----------------
	logic en;
	logic take;

	assign en       = !(ray_valid && ray_stall);
	assign uv_stall = !en || (st_q != B_IDLE);
	assign take     = uv_valid && !uv_stall;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [15:0] ux_s1, uy_s1;
	logic               dg_s1;
	logic signed [48:0] pr_w [3];
	logic signed [48:0] pu_w [3];
	logic signed [48:0] pr_s2 [3];
	logic signed [48:0] pu_s2 [3];
	logic               dg_s2;
	logic signed [63:0] side_w [3];
	logic signed [63:0] sm_s3 [3];
	logic               dg_s3;
	logic [61:0]        mg_s4 [3];
	logic [2:0]         sg_s4;
	logic               dg_s4;
	logic [61:0]        or_w;
	logic [5:0]         pos_w;
	logic [61:0]        mg_s5 [3];
	logic [5:0]         pos_s5;
	logic [2:0]         sg_s5;
	logic               dg_s5;
	logic [29:0]        m_s6 [3];
	logic [2:0]         sg_s6;
	logic               dg_s6;
	logic [59:0]        sq_w [3];
	logic [59:0]        sq_s7 [3];
	logic [29:0]        m_s7 [3];
	logic [2:0]         sg_s7;
	logic               dg_s7;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pr_w[c]   = ux_s1 * r_q[c];
			pu_w[c]   = uy_s1 * u_q[c];
			side_w[c] = 64'(pr_s2[c]) + 64'(pu_s2[c]);
			sq_w[c]   = m_s6[c] * m_s6[c];
		end
		or_w  = mg_s4[0] | mg_s4[1] | mg_s4[2];
		pos_w = '0;
		for (int j = 0; j < 62; j++)
			if (or_w[j]) pos_w = 6'(j);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= uv_data.uv_x;
			uy_s1 <= uv_data.uv_y;
			dg_s1 <= bdeg_q;

			pr_s2 <= pr_w;
			pu_s2 <= pu_w;
			dg_s2 <= dg_s1;

			for (int c = 0; c < 3; c++) sm_s3[c] <= fz_q[c] + (side_w[c] <<< 2);
			dg_s3 <= dg_s2;

			for (int c = 0; c < 3; c++) begin
				mg_s4[c] <= sm_s3[c][63] ? 62'(-sm_s3[c]) : 62'(sm_s3[c]);
				sg_s4[c] <= sm_s3[c][63];
			end
			dg_s4 <= dg_s3;

			mg_s5  <= mg_s4;
			pos_s5 <= pos_w;
			sg_s5  <= sg_s4;
			dg_s5  <= dg_s4 | (or_w == '0);

			// bring the largest magnitude into [2^29, 2^30)
			for (int c = 0; c < 3; c++)
				m_s6[c] <= (pos_s5 >= 6'd29) ? 30'(mg_s5[c] >> (pos_s5 - 6'd29))
				                             : 30'(mg_s5[c] << (6'd29 - pos_s5));
			sg_s6 <= sg_s5;
			dg_s6 <= dg_s5;

			sq_s7 <= sq_w;
			m_s7  <= m_s6;
			sg_s7 <= sg_s6;
			dg_s7 <= dg_s6;
		end
	end

	// square root, one result bit per stage; index 0 holds the sum of squares
	logic        rt_v_s  [33];
	logic [63:0] rt_x_s  [32];
	logic [63:0] rt_r_s  [33];
	logic [29:0] rt_m_s  [33][3];
	logic [2:0]  rt_sg_s [33];
	logic        rt_dg_s [33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rt_v_s[0] <= 1'b0;
		else if (en) rt_v_s[0] <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_x_s[0]  <= 64'(sq_s7[0]) + 64'(sq_s7[1]) + 64'(sq_s7[2]);
			rt_r_s[0]  <= '0;
			rt_m_s[0]  <= m_s7;
			rt_sg_s[0] <= sg_s7;
			rt_dg_s[0] <= dg_s7;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_rt
		localparam logic [63:0] RBIT = 64'd1 << (62 - 2 * k);
		logic [63:0] t;
		logic        ge;

		assign t  = rt_r_s[k] + RBIT;
		assign ge = rt_x_s[k] >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rt_v_s[k+1] <= 1'b0;
			else if (en) rt_v_s[k+1] <= rt_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_r_s[k+1]  <= ge ? (rt_r_s[k] >> 1) + RBIT : rt_r_s[k] >> 1;
				rt_m_s[k+1]  <= rt_m_s[k];
				rt_sg_s[k+1] <= rt_sg_s[k];
				rt_dg_s[k+1] <= rt_dg_s[k];
			end
		end

		if (k < 31) begin : g_x
			always_ff @(posedge clk) begin
				if (en) rt_x_s[k+1] <= ge ? rt_x_s[k] - t : rt_x_s[k];
			end
		end
	end

	// restoring divide, one quotient bit per stage, rounded by adding half the divisor
	logic        dv_v_s  [16];
	logic [45:0] dv_r_s  [15][3];
	logic [31:0] dv_n_s  [15];
	logic [14:0] dv_q_s  [16][3];
	logic [2:0]  dv_sg_s [16];
	logic        dv_dg_s [16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= rt_v_s[32];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				dv_r_s[0][c] <= (46'(rt_m_s[32][c]) << 14) + 46'(rt_r_s[32][31:1]);
				dv_q_s[0][c] <= '0;
			end
			dv_n_s[0]  <= rt_r_s[32][31:0];
			dv_sg_s[0] <= rt_sg_s[32];
			dv_dg_s[0] <= rt_dg_s[32];
		end
	end

	for (genvar j = 0; j < 15; j++) begin : g_dv
		localparam int K = 14 - j;
		logic [45:0] dsh;
		logic        ge [3];

		assign dsh = 46'(dv_n_s[j]) << K;
		always_comb begin
			for (int c = 0; c < 3; c++) ge[c] = dv_r_s[j][c] >= dsh;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[j+1] <= 1'b0;
			else if (en) dv_v_s[j+1] <= dv_v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++)
					dv_q_s[j+1][c] <= dv_q_s[j][c] | (15'(ge[c]) << K);
				dv_sg_s[j+1] <= dv_sg_s[j];
				dv_dg_s[j+1] <= dv_dg_s[j];
			end
		end

		if (j < 14) begin : g_r
			always_ff @(posedge clk) begin
				if (en) begin
					for (int c = 0; c < 3; c++)
						dv_r_s[j+1][c] <= ge[c] ? dv_r_s[j][c] - dsh : dv_r_s[j][c];
					dv_n_s[j+1] <= dv_n_s[j];
				end
			end
		end
	end

	// output register
	logic               ray_v_q;
	ray_t               ray_q;
	logic signed [15:0] dir_w [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dv_dg_s[15]) dir_w[c] = '0;
			else if (dv_sg_s[15][c]) dir_w[c] = -$signed({1'b0, dv_q_s[15][c]});
			else dir_w[c] = $signed({1'b0, dv_q_s[15][c]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ray_v_q <= 1'b0;
		else if (en) ray_v_q <= dv_v_s[15];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_q.dir_x      <= dir_w[0];
			ray_q.dir_y      <= dir_w[1];
			ray_q.dir_z      <= dir_w[2];
			ray_q.degenerate <= dv_dg_s[15];
		end
	end

	assign ray_valid = ray_v_q;
	assign ray_data  = ray_q;

endmodule
